// ===== sv/eartm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_pkg: shared types and constants
// Q2.30 CORDIC constants, arctangent table and angle convention codes.
// ----------------------------------------------------------------------------
package eartm_pkg;

	localparam int QBITS = 30;
	localparam int DW    = 34;

	typedef logic signed [DW-1:0] q_t;
	typedef logic signed [67:0]   p_t;

	typedef enum logic {
		KIND_XYZ = 1'b0,
		KIND_ZYX = 1'b1
	} kind_t;

	localparam q_t Q_ONE      = q_t'(64'sd1073741824);
	localparam q_t Q_HALF_PI  = q_t'(64'sh6487ED51);
	localparam q_t Q_PI       = q_t'(64'shC90FDAA2);
	localparam q_t Q_GAIN_INV = q_t'(64'sh26DD3B6A);

	function automatic q_t atan_q(input int k);
		logic [31:0] v;
		begin
			case (k)
				0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
				3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
				6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
				9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
				12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
				15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
				18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
				21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
				24: v = 32'h0000003F; 25: v = 32'h0000001F; 26: v = 32'h0000000F;
				27: v = 32'h00000008; 28: v = 32'h00000004; 29: v = 32'h00000002;
				30: v = 32'h00000001;
				default: v = 32'h00000000;
			endcase
			atan_q = q_t'({2'b00, v});
		end
	endfunction

endpackage

// ===== sv/eartm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_if: valid/ready channel
// Carries one beat of payload of type PAYLOAD_T between a source and a sink.
// ----------------------------------------------------------------------------
interface eartm_if #(
	parameter type PAYLOAD_T = logic
);
	logic     valid;
	logic     ready;
	PAYLOAD_T data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/euler_angles_to_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix: Euler angles to 3x3 rotation matrix
// Pipelined CORDIC sine/cosine, product stages, rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one pose per beat: kind (0 Euler XYZ, 1 Euler ZYX) and three
//   signed Q3.(ANGLE_WIDTH-3) angles. out_ch carries the nine matrix entries,
//   row major, signed Q1.(ENTRY_WIDTH-2), clamped to plus or minus one.
//   Throughput: one beat per cycle while the output is not stalled. The pipe
//   holds CORDIC_STEPS + 5 register stages, and the CORDIC pipeline
//   (one step per stage) sets their number.
//   Stages: entry register, CORDIC_STEPS rotation stages, two-factor product,
//   three-factor product, sum and round, then the output register.
//   The whole pipe moves as one: when the receiver stalls with a result in
//   the output register, every stage holds and in_ch.ready drops, so nothing
//   is lost or repeated. Bubbles travel with the pipe and are not removed.
//   Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module euler_angles_to_rotation_matrix #(
	parameter int ANGLE_WIDTH  = 16,
	parameter int ENTRY_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	eartm_if.sink   in_ch,
	eartm_if.source out_ch
);
	localparam int QB   = eartm_pkg::QBITS;
	localparam int SH   = 2*QB - (ENTRY_WIDTH - 2);
	localparam int LAT  = CORDIC_STEPS + 5;

	typedef logic signed [ENTRY_WIDTH-1:0] ent_t;

	// Valid bits, one per stage; last one is the output register.
	logic [LAT-1:0] v_q;
	logic           adv;

	// Advance unless the output register holds a beat nobody takes.
	assign adv         = !v_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], in_ch.valid};
		end
	end

	// Kind rides alongside the CORDIC stages.
	logic kind_d [CORDIC_STEPS+1];
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_d[0] <= in_ch.data.kind;
			for (int i = 0; i < CORDIC_STEPS; i++) kind_d[i+1] <= kind_d[i];
		end
	end

	eartm_pkg::q_t sa, ca, sb, cb, sg, cg;

	eartm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_ca (
		.clk(clk), .adv(adv), .angle(in_ch.data.first_angle), .sin_o(sa), .cos_o(ca));
	eartm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cb (
		.clk(clk), .adv(adv), .angle(in_ch.data.second_angle), .sin_o(sb), .cos_o(cb));
	eartm_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_cg (
		.clk(clk), .adv(adv), .angle(in_ch.data.third_angle), .sin_o(sg), .cos_o(cg));

	// Stage A: sin/cos registered, sa*sb and ca*sb formed.
	eartm_pkg::q_t  sa_s1, ca_s1, sb_s1, cb_s1, sg_s1, cg_s1, ssb_s1, csb_s1;
	logic           kind_s1;
	eartm_pkg::p_t  ssb_full, csb_full;
	assign ssb_full = eartm_pkg::p_t'(sa) * eartm_pkg::p_t'(sb);
	assign csb_full = eartm_pkg::p_t'(ca) * eartm_pkg::p_t'(sb);

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s1 <= sa; ca_s1 <= ca; sb_s1 <= sb;
			cb_s1 <= cb; sg_s1 <= sg; cg_s1 <= cg;
			ssb_s1  <= eartm_pkg::q_t'(ssb_full >>> QB);
			csb_s1  <= eartm_pkg::q_t'(csb_full >>> QB);
			kind_s1 <= kind_d[CORDIC_STEPS];
		end
	end

	// Stage B: all Q4.60 products needed by either convention.
	eartm_pkg::p_t p_s2 [16];
	logic          kind_s2;

	function automatic eartm_pkg::p_t mul(input eartm_pkg::q_t a, input eartm_pkg::q_t b);
		mul = eartm_pkg::p_t'(a) * eartm_pkg::p_t'(b);
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0]  <= mul(cb_s1, cg_s1);
			p_s2[1]  <= mul(cb_s1, sg_s1);
			p_s2[2]  <= mul(sb_s1, eartm_pkg::Q_ONE);
			p_s2[3]  <= mul(ssb_s1, cg_s1);
			p_s2[4]  <= mul(ca_s1, sg_s1);
			p_s2[5]  <= mul(ssb_s1, sg_s1);
			p_s2[6]  <= mul(ca_s1, cg_s1);
			p_s2[7]  <= mul(sa_s1, cb_s1);
			p_s2[8]  <= mul(csb_s1, cg_s1);
			p_s2[9]  <= mul(sa_s1, sg_s1);
			p_s2[10] <= mul(csb_s1, sg_s1);
			p_s2[11] <= mul(sa_s1, cg_s1);
			p_s2[12] <= mul(ca_s1, cb_s1);
			p_s2[13] <= '0;
			p_s2[14] <= '0;
			p_s2[15] <= '0;
			kind_s2  <= kind_s1;
		end
	end

	// Stage C: sums, rounding and saturation.
	eartm_pkg::p_t e [9];
	ent_t          r_s3 [9];

	function automatic ent_t to_entry(input eartm_pkg::p_t v);
		eartm_pkg::p_t r;
		eartm_pkg::p_t lim;
		begin
			lim = eartm_pkg::p_t'(1) <<< (ENTRY_WIDTH - 2);
			r = (v + (eartm_pkg::p_t'(1) <<< (SH - 1))) >>> SH;
			if (r > lim) r = lim;
			if (r < -lim) r = -lim;
			to_entry = ent_t'(r);
		end
	endfunction

	always_comb begin
		if (kind_s2 == eartm_pkg::KIND_XYZ) begin
			e[0] = p_s2[0];
			e[1] = -p_s2[1];
			e[2] = p_s2[2];
			e[3] = p_s2[3] + p_s2[4];
			e[4] = -p_s2[5] + p_s2[6];
			e[5] = -p_s2[7];
			e[6] = -p_s2[8] + p_s2[9];
			e[7] = p_s2[10] + p_s2[11];
			e[8] = p_s2[12];
		end else begin
			e[0] = p_s2[12];
			e[1] = p_s2[10] - p_s2[11];
			e[2] = p_s2[8] + p_s2[9];
			e[3] = p_s2[7];
			e[4] = p_s2[5] + p_s2[6];
			e[5] = p_s2[3] - p_s2[4];
			e[6] = -p_s2[2];
			e[7] = p_s2[1];
			e[8] = p_s2[0] + p_s2[13] + p_s2[14] + p_s2[15];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) r_s3[k] <= to_entry(e[k]);
		end
	end

	// Output register.
	ent_t o_q [9];
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 9; k++) o_q[k] <= r_s3[k];
		end
	end

	assign out_ch.valid           = v_q[LAT-1];
	assign out_ch.data.entry_r0c0 = o_q[0];
	assign out_ch.data.entry_r0c1 = o_q[1];
	assign out_ch.data.entry_r0c2 = o_q[2];
	assign out_ch.data.entry_r1c0 = o_q[3];
	assign out_ch.data.entry_r1c1 = o_q[4];
	assign out_ch.data.entry_r1c2 = o_q[5];
	assign out_ch.data.entry_r2c0 = o_q[6];
	assign out_ch.data.entry_r2c1 = o_q[7];
	assign out_ch.data.entry_r2c2 = o_q[8];
endmodule

// ===== sv/eartm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_cordic: pipelined sine/cosine
// One rotation step per stage; quadrant fold at entry, sign flip at exit.
// ----------------------------------------------------------------------------
module eartm_cordic #(
	parameter int ANGLE_WIDTH  = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          adv,
	input  logic signed [ANGLE_WIDTH-1:0] angle,
	output eartm_pkg::q_t                 sin_o,
	output eartm_pkg::q_t                 cos_o
);
	localparam int SH = eartm_pkg::QBITS - (ANGLE_WIDTH - 3);

	eartm_pkg::q_t x_s [CORDIC_STEPS+1];
	eartm_pkg::q_t y_s [CORDIC_STEPS+1];
	eartm_pkg::q_t z_s [CORDIC_STEPS+1];
	logic          f_s [CORDIC_STEPS+1];

	eartm_pkg::q_t z_in;
	eartm_pkg::q_t z_fold;
	logic          flip;

	always_comb begin
		z_in = eartm_pkg::q_t'(angle) <<< SH;
		flip = 1'b0;
		z_fold = z_in;
		if (z_in > eartm_pkg::Q_HALF_PI) begin
			z_fold = z_in - eartm_pkg::Q_PI;
			flip = 1'b1;
		end else if (z_in < -eartm_pkg::Q_HALF_PI) begin
			z_fold = z_in + eartm_pkg::Q_PI;
			flip = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= eartm_pkg::Q_GAIN_INV;
			y_s[0] <= '0;
			z_s[0] <= z_fold;
			f_s[0] <= flip;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam int K = i % 32;
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_s[i][eartm_pkg::DW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> K);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> K);
					z_s[i+1] <= z_s[i] - eartm_pkg::atan_q(K);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> K);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> K);
					z_s[i+1] <= z_s[i] + eartm_pkg::atan_q(K);
				end
				f_s[i+1] <= f_s[i];
			end
		end
	end

	assign sin_o = f_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS];
	assign cos_o = f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
endmodule

// ===== sv/eartm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_sva: port-level checks
// Handshake and pipeline flow rules seen at the top-level ports.
// ----------------------------------------------------------------------------
module eartm_sva (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	// Output beat holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output beat dropped while stalled");

	// The pipe stalls only because the output is stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// A ready output means the input is ready.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input not ready while output ready");

	// Nothing comes out right after reset.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid during reset");
endmodule

bind euler_angles_to_rotation_matrix eartm_sva u_eartm_sva (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready));

// ===== verif/eartm_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_tb_pkg: beat layouts for the rotation matrix bench
// Pose and matrix payload structs shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package eartm_tb_pkg;
	import eartm_pkg::*;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] first_angle;
		logic signed [15:0] second_angle;
		logic signed [15:0] third_angle;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] entry_r0c0;
		logic signed [15:0] entry_r0c1;
		logic signed [15:0] entry_r0c2;
		logic signed [15:0] entry_r1c0;
		logic signed [15:0] entry_r1c1;
		logic signed [15:0] entry_r1c2;
		logic signed [15:0] entry_r2c0;
		logic signed [15:0] entry_r2c1;
		logic signed [15:0] entry_r2c2;
	} matrix_t;
endpackage

// ===== verif/eartm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eartm_checker: rotation matrix scoreboard
// Computes the expected matrix of every accepted pose and compares each
// output beat against the oldest expected matrix, entry by entry.
// ----------------------------------------------------------------------------
module eartm_checker (
	input  logic clk,
	input  logic arst_n,
	eartm_if     in_mon,
	eartm_if     out_mon,
	output int   fail_count,
	output int   pending
);
	import eartm_pkg::*;
	import eartm_tb_pkg::*;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sh6487ED51;
	localparam longint PI_Q30      = 64'shC90FDAA2;
	localparam longint GAIN_Q30    = 64'sh26DD3B6A;
	localparam int     STEPS       = 16;

	localparam longint ARCTAN [0:15] = '{
		64'sh3243F6A8, 64'sh1DAC6705, 64'sh0FADBAFC, 64'sh07F56EA6,
		64'sh03FEAB76, 64'sh01FFD55B, 64'sh00FFFAAA, 64'sh007FFF55,
		64'sh003FFFEA, 64'sh001FFFFD, 64'sh000FFFFF, 64'sh0007FFFF,
		64'sh0003FFFF, 64'sh0001FFFF, 64'sh0000FFFF, 64'sh00007FFF
	};

	localparam string ENTRY_NAME [0:8] = '{
		"entry_r0c0", "entry_r0c1", "entry_r0c2",
		"entry_r1c0", "entry_r1c1", "entry_r1c2",
		"entry_r2c0", "entry_r2c1", "entry_r2c2"
	};

	matrix_t expected_matrices [$];

	// Fold into [-pi/2, pi/2], rotate, negate back if folded.
	function automatic void cordic_sin_cos(input logic signed [15:0] angle,
			output longint s, output longint c);
		longint z, x, y, nx;
		bit     folded;
		z = longint'(angle) * (64'sd1 << 17);
		x = GAIN_Q30;
		y = 0;
		folded = 0;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			folded = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			folded = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		s = folded ? -y : y;
		c = folded ? -x : x;
	endfunction

	// Q4.60 sum to Q1.14: round half up, clamp to plus or minus one.
	function automatic logic signed [15:0] round_entry(input longint v);
		longint r;
		r = (v + (64'sd1 << 45)) >>> 46;
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return r[15:0];
	endfunction

	function automatic matrix_t rotation_of(input pose_t p);
		longint sa, ca, sb, cb, sg, cg, ssb, csb;
		longint e [0:8];
		matrix_t m;
		cordic_sin_cos(p.first_angle, sa, ca);
		cordic_sin_cos(p.second_angle, sb, cb);
		cordic_sin_cos(p.third_angle, sg, cg);
		ssb = (sa * sb) >>> 30;
		csb = (ca * sb) >>> 30;
		if (p.kind == KIND_XYZ) begin
			e[0] = cb * cg;
			e[1] = -(cb * sg);
			e[2] = sb * ONE_Q30;
			e[3] = ssb * cg + ca * sg;
			e[4] = -(ssb * sg) + ca * cg;
			e[5] = -(sa * cb);
			e[6] = -(csb * cg) + sa * sg;
			e[7] = csb * sg + sa * cg;
			e[8] = ca * cb;
		end else begin
			e[0] = ca * cb;
			e[1] = csb * sg - sa * cg;
			e[2] = csb * cg + sa * sg;
			e[3] = sa * cb;
			e[4] = ssb * sg + ca * cg;
			e[5] = ssb * cg - ca * sg;
			e[6] = -(sb * ONE_Q30);
			e[7] = cb * sg;
			e[8] = cb * cg;
		end
		m.entry_r0c0 = round_entry(e[0]);
		m.entry_r0c1 = round_entry(e[1]);
		m.entry_r0c2 = round_entry(e[2]);
		m.entry_r1c0 = round_entry(e[3]);
		m.entry_r1c1 = round_entry(e[4]);
		m.entry_r1c2 = round_entry(e[5]);
		m.entry_r2c0 = round_entry(e[6]);
		m.entry_r2c1 = round_entry(e[7]);
		m.entry_r2c2 = round_entry(e[8]);
		return m;
	endfunction

	initial fail_count = 0;
	initial pending = 0;

	always @(posedge clk) begin
		matrix_t want, got;
		logic [143:0] want_bits, got_bits;
		if (arst_n) begin
			if (in_mon.valid && in_mon.ready)
				expected_matrices.push_back(rotation_of(in_mon.data));
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (expected_matrices.size() == 0) begin
					$error("matrix beat with no pose outstanding");
					fail_count++;
				end else begin
					want = expected_matrices.pop_front();
					want_bits = want;
					got_bits  = got;
					for (int k = 0; k < 9; k++)
						if (want_bits[143-16*k -: 16] !== got_bits[143-16*k -: 16]) begin
							$error("%s: expected %0d, got %0d", ENTRY_NAME[k],
								$signed(want_bits[143-16*k -: 16]),
								$signed(got_bits[143-16*k -: 16]));
							fail_count++;
						end
				end
			end
		end
		pending = expected_matrices.size();
	end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Euler angles to rotation matrix
// Drives directed and random poses of both conventions with random gaps and
// output stalls; a checker beside the block scores every matrix.
// ----------------------------------------------------------------------------
module testbench;
	import eartm_pkg::*;
	import eartm_tb_pkg::*;

	localparam int RANDOM_POSES = 1850;
	localparam int STALL_LIMIT  = 2000; // cycles without any beat
	localparam int DRAIN_CYCLES = 40;   // pipe depth is CORDIC steps + 5

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   sending_done;
	bit   quiet_phase;      // when set, both sides run without gaps
	int   idle_cycles;

	eartm_if #(.PAYLOAD_T(pose_t))   in_ch ();
	eartm_if #(.PAYLOAD_T(matrix_t)) out_ch ();

	euler_angles_to_rotation_matrix u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	eartm_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Drive every block input to a known value while reset is held, then release it.
	initial begin
		arst_n       = 0;
		in_ch.valid  = 0;
		in_ch.data   = '0;
		out_ch.ready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// Hold one pose on the input until it is taken; gap first if drawn.
	task automatic send_pose(input pose_t p);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data  <= p;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic signed [15:0] pick_angle();
		// Lean on the fold points at plus/minus pi/2 and the field extremes.
		case ($urandom_range(0, 9))
			0: return 16'(12868 + $signed($urandom_range(0, 6)) - 3);
			1: return 16'(-12868 + $signed($urandom_range(0, 6)) - 3);
			2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			3: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus: directed corners, then random poses.
	initial begin
		pose_t p;
		logic signed [15:0] corners [0:10] = '{16'sd0, 16'sh7FFF, 16'sh8000,
			16'sd12868, 16'sd12869, -16'sd12868, -16'sd12869, 16'sd25736,
			-16'sd25736, 16'sd1, -16'sd1};
		sending_done = 0;
		quiet_phase  = 0;
		@(posedge arst_n);
		@(posedge clk);
		for (int i = 0; i < 22; i++) begin
			p.kind         = (i % 2) ? KIND_ZYX : KIND_XYZ;
			p.first_angle  = corners[(i / 2) % 11];
			p.second_angle = corners[(i / 2 + 3) % 11];
			p.third_angle  = corners[(i / 2 + 7) % 11];
			send_pose(p);
		end
		for (int i = 0; i < RANDOM_POSES; i++) begin
			// Alternate stretches of back-to-back traffic with gappy ones.
			if (i % 150 == 0)
				quiet_phase = ($urandom_range(0, 2) == 0);
			p.kind         = kind_t'($urandom_range(0, 1));
			p.first_angle  = pick_angle();
			p.second_angle = pick_angle();
			p.third_angle  = pick_angle();
			send_pose(p);
		end
		in_ch.valid  <= 0;
		sending_done = 1;
	end

	// Receiver: stall a drawn number of cycles, then take one matrix beat.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = quiet_phase ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Watchdog: count cycles in which neither channel moves a beat.
	initial begin
		idle_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Verdict: let the last pose land, drain, wait out the pipe, then report.
	initial begin
		wait (sending_done);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
